// ===== hw/rtl/fxa_pkg.sv =====
// ----------------------------------------------------------------------------
// fxa_pkg: shared types and helpers for the fixed-point ALU
// Opcodes, status codes, request/response structs and the 32-bit saturator.
// ----------------------------------------------------------------------------
package fxa_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_GE      = 4'd5,
    OP_LT      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

  // which back-end path finishes the request
  typedef enum logic [1:0] {
    K_SIMPLE = 2'd0,
    K_MUL    = 2'd1,
    K_DIV    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic [1:0]         status;
  } rsp_t;

  // classified request, front to back
  typedef struct packed {
    op_e                op;
    kind_e              kind;
    logic               neg;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        mag_a;
    logic [31:0]        mag_b;
  } cls_t;

  // control carried down the back-end pipeline
  typedef struct packed {
    kind_e       kind;
    logic        neg;
    logic [31:0] dvs;
    rsp_t        rsp;
  } ctl_t;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic signed [63:0] RawMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] RawMin = -64'sh0000_0000_8000_0000;

  function automatic rsp_t sat64(input logic signed [63:0] v);
    rsp_t r;
    r.compare_true = 1'b0;
    r.status       = ST_OK;
    if (v > RawMax) begin
      r.result = 32'sh7FFF_FFFF;
      r.status = ST_OVF;
    end else if (v < RawMin) begin
      r.result = 32'sh8000_0000;
      r.status = ST_OVF;
    end else begin
      r.result = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/fxa_fifo.sv =====
// ----------------------------------------------------------------------------
// fxa_fifo: short queue between front end and back end
// Register-based FIFO of classified requests.
// ----------------------------------------------------------------------------
module fxa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fxa_pkg::cls_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output fxa_pkg::cls_t rdata_o,
  output logic          empty_o
);

  fxa_pkg::cls_t                   mem_q [fxa_pkg::QDepth];
  logic [fxa_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [fxa_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [fxa_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == fxa_pkg::QCntW'(fxa_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/fxa_front.sv =====
// ----------------------------------------------------------------------------
// fxa_front: request intake and classification
// Registers one request, decodes the opcode and precomputes magnitudes.
// ----------------------------------------------------------------------------
module fxa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  fxa_pkg::req_t req_i,
  output logic          q_push_o,
  output fxa_pkg::cls_t q_item_o,
  input  logic          q_full_i
);

  logic          vld_q;
  fxa_pkg::cls_t item_q, item_d;
  logic          take;

  assign full     = vld_q && q_full_i;
  assign take     = push && !full;
  assign q_push_o = vld_q;
  assign q_item_o = item_q;

  always_comb begin
    item_d.op    = fxa_pkg::op_e'(req_i.mode);
    item_d.a     = req_i.operand_a;
    item_d.b     = req_i.operand_b;
    item_d.neg   = req_i.operand_a[31] ^ req_i.operand_b[31];
    item_d.mag_a = req_i.operand_a[31] ? 32'(-req_i.operand_a) : 32'(req_i.operand_a);
    item_d.mag_b = req_i.operand_b[31] ? 32'(-req_i.operand_b) : 32'(req_i.operand_b);
    item_d.kind  = fxa_pkg::K_SIMPLE;
    if (item_d.op == fxa_pkg::OP_MUL) begin
      item_d.kind = fxa_pkg::K_MUL;
    end else if (item_d.op == fxa_pkg::OP_DIV && req_i.operand_b != '0) begin
      // divide by zero is resolved up front, not in the divider
      item_d.kind = fxa_pkg::K_DIV;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (!q_full_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== hw/rtl/fxa_back.sv =====
// ----------------------------------------------------------------------------
// fxa_back: execution pipeline
// Simple ops and the multiply in the first stage, a radix-2 divider with one
// stage per quotient bit, rounding/saturation, and the result register.
// ----------------------------------------------------------------------------
module fxa_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  input  fxa_pkg::cls_t q_item_i,
  output logic          empty,
  input  logic          pop,
  output fxa_pkg::rsp_t rsp_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;  // dividend / quotient width

  logic                vld_q [NW+2];
  fxa_pkg::ctl_t       ctl_q [NW+1];
  logic [31:0]         rem_q [NW+1];
  logic [NW-1:0]       nq_q  [NW+1];
  logic [63:0]         prod_q;
  fxa_pkg::rsp_t       out_q;

  logic                en;
  fxa_pkg::ctl_t       ctl0_d, ctl1_d;
  fxa_pkg::rsp_t       out_d;
  fxa_pkg::cls_t       h;
  logic signed [63:0]  a64, b64;
  logic                flag;
  logic [63:0]         qm;
  logic [NW:0]         qd;

  // one restoring-division step: shift in the next dividend bit
  function automatic logic [32+NW-1:0] div_step(input logic [31:0]   rem,
                                                input logic [NW-1:0] nq,
                                                input logic [31:0]   dvs);
    logic [32:0] trial;
    logic [31:0] rn;
    logic        qbit;
    trial = {rem, nq[NW-1]};
    if (trial >= {1'b0, dvs}) begin
      rn   = 32'(trial - {1'b0, dvs});
      qbit = 1'b1;
    end else begin
      rn   = trial[31:0];
      qbit = 1'b0;
    end
    return {rn, nq[NW-2:0], qbit};
  endfunction

  assign en      = !vld_q[NW+1] || pop;
  assign q_pop_o = en && !q_empty_i;
  assign empty   = !vld_q[NW+1];
  assign rsp_o   = out_q;
  assign h       = q_item_i;
  assign a64     = 64'(h.a);
  assign b64     = 64'(h.b);

  // stage 0: everything that is not multiply or divide, plus the divide-by-zero result
  always_comb begin
    ctl0_d.kind = h.kind;
    ctl0_d.neg  = h.neg;
    ctl0_d.dvs  = h.mag_b;
    ctl0_d.rsp  = '0;
    flag        = 1'b0;
    unique case (h.op)
      fxa_pkg::OP_ADD:     ctl0_d.rsp = fxa_pkg::sat64(a64 + b64);
      fxa_pkg::OP_SUB:     ctl0_d.rsp = fxa_pkg::sat64(a64 - b64);
      fxa_pkg::OP_MUL:     ctl0_d.rsp = '0;
      fxa_pkg::OP_DIV: begin
        if (h.kind == fxa_pkg::K_SIMPLE) begin
          ctl0_d.rsp.result = h.a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          ctl0_d.rsp.status = fxa_pkg::ST_DIVZ;
        end
      end
      fxa_pkg::OP_GT:      flag = h.a > h.b;
      fxa_pkg::OP_GE:      flag = h.a >= h.b;
      fxa_pkg::OP_LT:      flag = h.a < h.b;
      fxa_pkg::OP_LE:      flag = h.a <= h.b;
      fxa_pkg::OP_EQ:      flag = h.a == h.b;
      fxa_pkg::OP_NE:      flag = h.a != h.b;
      fxa_pkg::OP_MIN:     ctl0_d.rsp.result = (h.a < h.b) ? h.a : h.b;
      fxa_pkg::OP_MAX:     ctl0_d.rsp.result = (h.a > h.b) ? h.a : h.b;
      fxa_pkg::OP_INC:     ctl0_d.rsp = fxa_pkg::sat64(a64 + 64'sd1);
      fxa_pkg::OP_DEC:     ctl0_d.rsp = fxa_pkg::sat64(a64 - 64'sd1);
      fxa_pkg::OP_TOINT:   ctl0_d.rsp.result = h.a >>> FRAC_BITS;
      fxa_pkg::OP_FROMINT: ctl0_d.rsp = fxa_pkg::sat64(a64 <<< FRAC_BITS);
    endcase
    if (flag) begin
      ctl0_d.rsp.result       = 32'sd1;
      ctl0_d.rsp.compare_true = 1'b1;
    end
  end

  // stage 1: round and saturate the registered product
  always_comb begin
    ctl1_d = ctl_q[0];
    qm     = (prod_q >> FRAC_BITS) + 64'(prod_q[FRAC_BITS-1]);
    if (ctl_q[0].kind == fxa_pkg::K_MUL) begin
      ctl1_d.rsp = fxa_pkg::sat64(ctl_q[0].neg ? -$signed(qm) : $signed(qm));
    end
  end

  // output stage: round and saturate the quotient
  always_comb begin
    out_d = ctl_q[NW].rsp;
    qd    = {1'b0, nq_q[NW]} + (NW+1)'({rem_q[NW], 1'b0} >= {1'b0, ctl_q[NW].dvs});
    if (ctl_q[NW].kind == fxa_pkg::K_DIV) begin
      out_d = fxa_pkg::sat64(ctl_q[NW].neg ? -$signed(64'(qd)) : $signed(64'(qd)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NW + 2; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= !q_empty_i;
      for (int k = 1; k < NW + 2; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0]  <= ctl0_d;
      prod_q    <= 64'(h.mag_a) * 64'(h.mag_b);
      rem_q[0]  <= '0;
      nq_q[0]   <= NW'(h.mag_a) << FRAC_BITS;
      ctl_q[1]  <= ctl1_d;
      for (int k = 1; k <= NW; k++) begin
        {rem_q[k], nq_q[k]} <= div_step(rem_q[k-1], nq_q[k-1], ctl_q[k-1].dvs);
      end
      for (int k = 2; k <= NW; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
      out_q <= out_d;
    end
  end

endmodule

// ===== hw/rtl/fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu: signed fixed-point ALU (Q(32-FRAC_BITS).FRAC_BITS)
// Add, sub, multiply, divide, compares, min/max, inc/dec and int conversion.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue write port: a request is taken on a clock edge
//   with push high and full low. Response side is a queue read port: the
//   oldest response sits on rsp_o while empty is low and is taken on an edge
//   with pop high. Exactly one response per request, in request order.
//   Every opcode takes the same path from the accepting edge to the response.
//   Its length is set by the divider, one pipeline stage per quotient bit
//   (32 + FRAC_BITS bits), plus intake, queue, first stage and the result
//   register.
//   Throughput: one request per cycle, sustained while pop takes each response.
//   When a response is waiting and pop stays low the whole back-end pipeline
//   holds; the 2-entry queue and the intake register then fill and full rises.
//   Reset clears all valid state; nothing else needs initializing.
// ----------------------------------------------------------------------------
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  fxa_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output fxa_pkg::rsp_t rsp_o
);

  logic          q_push, q_full, q_pop, q_empty;
  fxa_pkg::cls_t q_wdata, q_rdata;

  fxa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .req_i    (req_i),
    .q_push_o (q_push),
    .q_item_o (q_wdata),
    .q_full_i (q_full)
  );

  fxa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  fxa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .q_item_i  (q_rdata),
    .empty     (empty),
    .pop       (pop),
    .rsp_o     (rsp_o)
  );

endmodule
